// ===== sv/nptri_pkg.sv =====
// Shared types and constants for the nearest-point-on-triangle pipeline.
// Used by the channel interfaces and by every nptri module; no dependencies.
package nptri_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;       // difference of two coordinates
  localparam int PROD_W  = 2 * DIFF_W;        // product of two differences
  localparam int DOT_W   = PROD_W;            // magnitude of t and |e-s|^2
  localparam int QUO_W   = DIFF_W;            // interpolation offset, below |d|
  localparam int PT_W    = COORD_W + 2;       // clamped point before saturation
  localparam int DIST_W  = 2 * (PT_W + 1) + 1;

  localparam int FRONT_STAGES = 3;
  localparam int DIV_STEPS    = QUO_W;
  localparam int PICK_STAGES  = 5;
  localparam int LATENCY      = FRONT_STAGES + DIV_STEPS + PICK_STAGES;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct packed {
    coord_t px;
    coord_t py;
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t cx;
    coord_t cy;
  } item_t;

  typedef enum logic [1:0] {
    CLAMP_START,
    CLAMP_END,
    CLAMP_LERP
  } clamp_t;

  // one edge's multiply-divide request: offset = m * t / ee per coordinate
  typedef struct packed {
    logic [DOT_W-1:0] t;
    logic [DOT_W-1:0] ee;
    logic [QUO_W-1:0] mx;
    logic [QUO_W-1:0] my;
  } div_req_t;

  typedef struct packed {
    clamp_t code;
    logic   negx;
    logic   negy;
  } eg_side_t;

  typedef struct packed {
    item_t              item;
    logic               in_tri;
    eg_side_t [2:0]     eg;
  } side_t;

endpackage

// ===== sv/nptri_query_if.sv =====
// Query channel: valid/ready handshake carrying the point and three vertices.
// Depends on nptri_pkg for the coordinate type.
interface nptri_query_if;
  logic             valid;
  logic             ready;
  nptri_pkg::coord_t point_x;
  nptri_pkg::coord_t point_y;
  nptri_pkg::coord_t vertex_a_x;
  nptri_pkg::coord_t vertex_a_y;
  nptri_pkg::coord_t vertex_b_x;
  nptri_pkg::coord_t vertex_b_y;
  nptri_pkg::coord_t vertex_c_x;
  nptri_pkg::coord_t vertex_c_y;

  modport source (output valid, point_x, point_y, vertex_a_x, vertex_a_y,
                  vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y, input ready);
  modport sink   (input valid, point_x, point_y, vertex_a_x, vertex_a_y,
                  vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y, output ready);
endinterface

// ===== sv/nptri_result_if.sv =====
// Result channel: valid/ready handshake carrying the nearest point and inside flag.
// Depends on nptri_pkg for the coordinate type.
interface nptri_result_if;
  logic              valid;
  logic              ready;
  nptri_pkg::coord_t near_x;
  nptri_pkg::coord_t near_y;
  logic              inside_res;

  modport source (output valid, near_x, near_y, inside_res, input ready);
  modport sink   (input valid, near_x, near_y, inside_res, output ready);
endinterface

// ===== sv/nptri_front.sv =====
// Front three stages: edge differences, products, dot/cross sums and clamp class.
// Depends on nptri_pkg.
module nptri_front (
  input  logic                          clk,
  input  logic                          en,
  input  nptri_pkg::item_t              item,
  output nptri_pkg::div_req_t [2:0]     req,
  output nptri_pkg::side_t              side
);

  nptri_pkg::coord_t vx [3];
  nptri_pkg::coord_t vy [3];

  // stage 1
  nptri_pkg::item_t                  item1;
  logic signed [nptri_pkg::DIFF_W-1:0] dx1 [3];
  logic signed [nptri_pkg::DIFF_W-1:0] dy1 [3];
  logic signed [nptri_pkg::DIFF_W-1:0] wx1 [3];
  logic signed [nptri_pkg::DIFF_W-1:0] wy1 [3];

  // stage 2
  nptri_pkg::item_t                    item2;
  logic signed [nptri_pkg::PROD_W-1:0] pc1 [3];
  logic signed [nptri_pkg::PROD_W-1:0] pc2 [3];
  logic signed [nptri_pkg::PROD_W-1:0] pt1 [3];
  logic signed [nptri_pkg::PROD_W-1:0] pt2 [3];
  logic signed [nptri_pkg::PROD_W-1:0] pu1 [3];
  logic signed [nptri_pkg::PROD_W-1:0] pu2 [3];
  logic signed [nptri_pkg::PROD_W-1:0] pe1 [3];
  logic signed [nptri_pkg::PROD_W-1:0] pe2 [3];
  logic                                negx2 [3];
  logic                                negy2 [3];
  logic [nptri_pkg::QUO_W-1:0]         mx2 [3];
  logic [nptri_pkg::QUO_W-1:0]         my2 [3];

  // stage 3 combinational sums
  logic signed [nptri_pkg::PROD_W:0] cr [3];
  logic signed [nptri_pkg::PROD_W:0] tt [3];
  logic signed [nptri_pkg::PROD_W:0] uu [3];
  logic signed [nptri_pkg::PROD_W:0] ee [3];
  nptri_pkg::div_req_t [2:0]         req_next;
  nptri_pkg::side_t                  side_next;

  always_comb begin
    vx[0] = item.ax;
    vx[1] = item.bx;
    vx[2] = item.cx;
    vy[0] = item.ay;
    vy[1] = item.by;
    vy[2] = item.cy;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item1 <= item;
      for (int k = 0; k < 3; k++) begin
        dx1[k] <= nptri_pkg::DIFF_W'(vx[(k == 2) ? 0 : k + 1])
                  - nptri_pkg::DIFF_W'(vx[k]);
        dy1[k] <= nptri_pkg::DIFF_W'(vy[(k == 2) ? 0 : k + 1])
                  - nptri_pkg::DIFF_W'(vy[k]);
        wx1[k] <= nptri_pkg::DIFF_W'(item.px) - nptri_pkg::DIFF_W'(vx[k]);
        wy1[k] <= nptri_pkg::DIFF_W'(item.py) - nptri_pkg::DIFF_W'(vy[k]);
      end
    end
  end

  // p - e of one edge is p - s of the next one
  always_ff @(posedge clk) begin
    if (en) begin
      item2 <= item1;
      for (int k = 0; k < 3; k++) begin
        pc1[k] <= dx1[k] * wy1[k];
        pc2[k] <= dy1[k] * wx1[k];
        pt1[k] <= dx1[k] * wx1[k];
        pt2[k] <= dy1[k] * wy1[k];
        pu1[k] <= dx1[k] * wx1[(k == 2) ? 0 : k + 1];
        pu2[k] <= dy1[k] * wy1[(k == 2) ? 0 : k + 1];
        pe1[k] <= dx1[k] * dx1[k];
        pe2[k] <= dy1[k] * dy1[k];
        negx2[k] <= dx1[k][nptri_pkg::DIFF_W-1];
        negy2[k] <= dy1[k][nptri_pkg::DIFF_W-1];
        mx2[k]   <= dx1[k][nptri_pkg::DIFF_W-1] ? nptri_pkg::QUO_W'(-dx1[k])
                                                : nptri_pkg::QUO_W'(dx1[k]);
        my2[k]   <= dy1[k][nptri_pkg::DIFF_W-1] ? nptri_pkg::QUO_W'(-dy1[k])
                                                : nptri_pkg::QUO_W'(dy1[k]);
      end
    end
  end

  always_comb begin
    side_next.item   = item2;
    side_next.in_tri = 1'b1;
    for (int k = 0; k < 3; k++) begin
      cr[k] = (nptri_pkg::PROD_W + 1)'(pc1[k]) - (nptri_pkg::PROD_W + 1)'(pc2[k]);
      tt[k] = (nptri_pkg::PROD_W + 1)'(pt1[k]) + (nptri_pkg::PROD_W + 1)'(pt2[k]);
      uu[k] = (nptri_pkg::PROD_W + 1)'(pu1[k]) + (nptri_pkg::PROD_W + 1)'(pu2[k]);
      ee[k] = (nptri_pkg::PROD_W + 1)'(pe1[k]) + (nptri_pkg::PROD_W + 1)'(pe2[k]);
      if (cr[k][nptri_pkg::PROD_W] || cr[k] == '0) begin
        side_next.in_tri = 1'b0;
      end
      side_next.eg[k].negx = negx2[k];
      side_next.eg[k].negy = negy2[k];
      req_next[k].ee = ee[k][nptri_pkg::DOT_W-1:0];
      req_next[k].mx = mx2[k];
      req_next[k].my = my2[k];
      req_next[k].t  = '0;
      if (tt[k][nptri_pkg::PROD_W] || tt[k] == '0) begin
        side_next.eg[k].code = nptri_pkg::CLAMP_START;
      end else if (!uu[k][nptri_pkg::PROD_W]) begin
        side_next.eg[k].code = nptri_pkg::CLAMP_END;
      end else begin
        // here 0 < t < ee, so the offset stays below |d|
        side_next.eg[k].code = nptri_pkg::CLAMP_LERP;
        req_next[k].t        = tt[k][nptri_pkg::DOT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      req  <= req_next;
      side <= side_next;
    end
  end

endmodule

// ===== sv/nptri_div.sv =====
// Pipelined multiply-divide for one edge: floor(m * t / ee) for x and y offsets.
// One bit of m per stage, radix-2 with digits 0..2. Depends on nptri_pkg.
module nptri_div (
  input  logic                         clk,
  input  logic                         en,
  input  nptri_pkg::div_req_t          req,
  output logic [nptri_pkg::QUO_W-1:0]  qx,
  output logic [nptri_pkg::QUO_W-1:0]  qy
);

  localparam int N = nptri_pkg::DIV_STEPS;

  typedef struct packed {
    logic [nptri_pkg::DOT_W-1:0] r;
    logic [nptri_pkg::QUO_W-1:0] q;
  } step_t;

  // remainder r < ee on entry; 2r + t < 3 ee
  function automatic step_t div_step(input logic [nptri_pkg::DOT_W-1:0] r,
                                     input logic [nptri_pkg::DOT_W-1:0] t,
                                     input logic [nptri_pkg::DOT_W-1:0] ee,
                                     input logic                        mbit,
                                     input logic [nptri_pkg::QUO_W-1:0] q);
    logic [nptri_pkg::DOT_W+1:0] acc;
    logic [nptri_pkg::DOT_W+1:0] ee1;
    logic [nptri_pkg::DOT_W+1:0] ee2;
    step_t                       s;
    acc = {1'b0, r, 1'b0} + (mbit ? {2'b00, t} : '0);
    ee1 = {2'b00, ee};
    ee2 = {1'b0, ee, 1'b0};
    if (acc >= ee2) begin
      s.r = nptri_pkg::DOT_W'(acc - ee2);
      s.q = {q[nptri_pkg::QUO_W-2:0], 1'b0} + nptri_pkg::QUO_W'(2);
    end else if (acc >= ee1) begin
      s.r = nptri_pkg::DOT_W'(acc - ee1);
      s.q = {q[nptri_pkg::QUO_W-2:0], 1'b1};
    end else begin
      s.r = nptri_pkg::DOT_W'(acc);
      s.q = {q[nptri_pkg::QUO_W-2:0], 1'b0};
    end
    return s;
  endfunction

  logic [nptri_pkg::DOT_W-1:0] t_s  [N];
  logic [nptri_pkg::DOT_W-1:0] ee_s [N];
  logic [nptri_pkg::QUO_W-1:0] mx_s [N];
  logic [nptri_pkg::QUO_W-1:0] my_s [N];
  step_t                       sx   [N];
  step_t                       sy   [N];

  always_ff @(posedge clk) begin
    if (en) begin
      t_s[0]  <= req.t;
      ee_s[0] <= req.ee;
      mx_s[0] <= req.mx;
      my_s[0] <= req.my;
      sx[0]   <= div_step('0, req.t, req.ee, req.mx[nptri_pkg::QUO_W-1], '0);
      sy[0]   <= div_step('0, req.t, req.ee, req.my[nptri_pkg::QUO_W-1], '0);
      for (int i = 1; i < N; i++) begin
        t_s[i]  <= t_s[i-1];
        ee_s[i] <= ee_s[i-1];
        mx_s[i] <= mx_s[i-1];
        my_s[i] <= my_s[i-1];
        sx[i]   <= div_step(sx[i-1].r, t_s[i-1], ee_s[i-1],
                            mx_s[i-1][nptri_pkg::QUO_W-1-i], sx[i-1].q);
        sy[i]   <= div_step(sy[i-1].r, t_s[i-1], ee_s[i-1],
                            my_s[i-1][nptri_pkg::QUO_W-1-i], sy[i-1].q);
      end
    end
  end

  assign qx = sx[N-1].q;
  assign qy = sy[N-1].q;

endmodule

// ===== sv/nptri_pick.sv =====
// Back five stages: clamped edge points, squared distances, nearest selection.
// The last stage is the result register. Depends on nptri_pkg.
module nptri_pick (
  input  logic                              clk,
  input  logic                              en,
  input  nptri_pkg::side_t                  side,
  input  logic [2:0][nptri_pkg::QUO_W-1:0]  qx,
  input  logic [2:0][nptri_pkg::QUO_W-1:0]  qy,
  output nptri_pkg::coord_t                 near_x,
  output nptri_pkg::coord_t                 near_y,
  output logic                              inside_res
);

  localparam int PW = nptri_pkg::PT_W;

  function automatic logic signed [PW-1:0] clamp_pt(input nptri_pkg::clamp_t code,
                                                    input nptri_pkg::coord_t s,
                                                    input nptri_pkg::coord_t e,
                                                    input logic neg,
                                                    input logic [nptri_pkg::QUO_W-1:0] q);
    logic signed [PW-1:0] qe;
    logic signed [PW-1:0] v;
    qe = signed'({1'b0, q});
    case (code)
      nptri_pkg::CLAMP_END:  v = PW'(e);
      nptri_pkg::CLAMP_LERP: v = neg ? PW'(s) - qe : PW'(s) + qe;
      default:               v = PW'(s);
    endcase
    return v;
  endfunction

  function automatic nptri_pkg::coord_t sat(input logic signed [PW-1:0] v);
    nptri_pkg::coord_t r;
    if (v[PW-1:nptri_pkg::COORD_W-1] == '0 || v[PW-1:nptri_pkg::COORD_W-1] == '1) begin
      r = v[nptri_pkg::COORD_W-1:0];
    end else begin
      r = v[PW-1] ? nptri_pkg::COORD_MIN : nptri_pkg::COORD_MAX;
    end
    return r;
  endfunction

  nptri_pkg::coord_t vx [3];
  nptri_pkg::coord_t vy [3];

  logic signed [PW-1:0]   cx1 [3], cy1 [3], cx2 [3], cy2 [3];
  logic signed [PW-1:0]   cx3 [3], cy3 [3], cx4 [3], cy4 [3];
  logic signed [PW:0]     ddx2 [3], ddy2 [3];
  logic signed [2*PW+1:0] sqx3 [3], sqy3 [3];
  logic [nptri_pkg::DIST_W-1:0] dist4 [3];
  nptri_pkg::coord_t      px1, py1, px2, py2, px3, py3, px4, py4;
  logic                   in1, in2, in3, in4;

  logic                   lt01, ge02, ge12;
  logic [1:0]             win;

  always_comb begin
    vx[0] = side.item.ax;
    vx[1] = side.item.bx;
    vx[2] = side.item.cx;
    vy[0] = side.item.ay;
    vy[1] = side.item.by;
    vy[2] = side.item.cy;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1 <= side.item.px;
      py1 <= side.item.py;
      in1 <= side.in_tri;
      for (int k = 0; k < 3; k++) begin
        cx1[k] <= clamp_pt(side.eg[k].code, vx[k], vx[(k == 2) ? 0 : k + 1],
                           side.eg[k].negx, qx[k]);
        cy1[k] <= clamp_pt(side.eg[k].code, vy[k], vy[(k == 2) ? 0 : k + 1],
                           side.eg[k].negy, qy[k]);
      end

      px2 <= px1;
      py2 <= py1;
      in2 <= in1;
      for (int k = 0; k < 3; k++) begin
        cx2[k]  <= cx1[k];
        cy2[k]  <= cy1[k];
        ddx2[k] <= (PW + 1)'(cx1[k]) - (PW + 1)'(px1);
        ddy2[k] <= (PW + 1)'(cy1[k]) - (PW + 1)'(py1);
      end

      px3 <= px2;
      py3 <= py2;
      in3 <= in2;
      for (int k = 0; k < 3; k++) begin
        cx3[k]  <= cx2[k];
        cy3[k]  <= cy2[k];
        sqx3[k] <= ddx2[k] * ddx2[k];
        sqy3[k] <= ddy2[k] * ddy2[k];
      end

      px4 <= px3;
      py4 <= py3;
      in4 <= in3;
      for (int k = 0; k < 3; k++) begin
        cx4[k]   <= cx3[k];
        cy4[k]   <= cy3[k];
        dist4[k] <= nptri_pkg::DIST_W'($unsigned(sqx3[k]))
                    + nptri_pkg::DIST_W'($unsigned(sqy3[k]));
      end
    end
  end

  // ties go to the later edge
  always_comb begin
    lt01 = dist4[0] <  dist4[1];
    ge02 = dist4[0] >= dist4[2];
    ge12 = dist4[1] >= dist4[2];
    if (lt01) begin
      win = ge02 ? 2'd2 : 2'd0;
    end else begin
      win = ge12 ? 2'd2 : 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inside_res <= in4;
      if (in4) begin
        near_x <= px4;
        near_y <= py4;
      end else begin
        near_x <= sat(cx4[win]);
        near_y <= sat(cy4[win]);
      end
    end
  end

endmodule

// ===== sv/nearest_point_on_triangle_2d.sv =====
// Nearest point on a 2-D triangle, signed Q16.16 in and out. One query is taken
// per cycle while the pipeline is not held, and each result passes three front
// stages (edge differences, products, dot and cross sums), 33 multiply-divide
// stages that produce the interpolation offset one bit per stage, and five back
// stages (clamped points, squared distances, selection and output register).
// When the result is not taken the whole pipeline holds; nothing is dropped or
// repeated. Depends on nptri_pkg, nptri_query_if, nptri_result_if, nptri_front,
// nptri_div and nptri_pick.
module nearest_point_on_triangle_2d (
  input  logic                  clk,
  input  logic                  rst,
  nptri_query_if.sink           query,
  nptri_result_if.source        result
);

  localparam int LAT = nptri_pkg::LATENCY;
  localparam int N   = nptri_pkg::DIV_STEPS;

  logic [LAT-1:0]                    vld;
  logic                              adv;
  nptri_pkg::item_t                  item;
  nptri_pkg::div_req_t [2:0]         req;
  nptri_pkg::side_t                  side_f;
  nptri_pkg::side_t                  side_d [N];
  logic [2:0][nptri_pkg::QUO_W-1:0]  qx;
  logic [2:0][nptri_pkg::QUO_W-1:0]  qy;

  // advance everything unless a finished result is waiting and not taken
  assign adv         = !vld[LAT-1] || result.ready;
  assign query.ready = adv;
  assign result.valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], query.valid};
    end
  end

  always_comb begin
    item.px = query.point_x;
    item.py = query.point_y;
    item.ax = query.vertex_a_x;
    item.ay = query.vertex_a_y;
    item.bx = query.vertex_b_x;
    item.by = query.vertex_b_y;
    item.cx = query.vertex_c_x;
    item.cy = query.vertex_c_y;
  end

  nptri_front u_front (
    .clk  (clk),
    .en   (adv),
    .item (item),
    .req  (req),
    .side (side_f)
  );

  for (genvar k = 0; k < 3; k++) begin : g_div
    nptri_div u_div (
      .clk (clk),
      .en  (adv),
      .req (req[k]),
      .qx  (qx[k]),
      .qy  (qy[k])
    );
  end

  // carry the query and edge classes alongside the divider
  always_ff @(posedge clk) begin
    if (adv) begin
      side_d[0] <= side_f;
      for (int i = 1; i < N; i++) begin
        side_d[i] <= side_d[i-1];
      end
    end
  end

  nptri_pick u_pick (
    .clk        (clk),
    .en         (adv),
    .side       (side_d[N-1]),
    .qx         (qx),
    .qy         (qy),
    .near_x     (result.near_x),
    .near_y     (result.near_y),
    .inside_res (result.inside_res)
  );

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("valid chain moved during a stall");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    adv |=> vld[0] == $past(query.valid))
    else $error("accepted request not tracked at pipeline entry");

  a_shift: assert property (@(posedge clk) disable iff (rst)
    adv |=> vld[LAT-1:1] == $past(vld[LAT-2:0]))
    else $error("valid chain lost or duplicated a request");

endmodule
